// File: rtl/smp_pkg.sv
// Shared types and constants for the STUN message parser.
// Used by smp_parse_core, smp_result_fifo and stun_message_parser; no dependencies.
package smp_pkg;

    localparam int HEADER_BYTES      = 20;
    localparam int TXN_HIGH_END      = 12;
    localparam int PAD_MASK          = 3;
    localparam int ATTR_HEADER_BYTES = 4;

    localparam int POS_W = 17;
    localparam int LEN_W = 16;

    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
    localparam logic [31:0]      COOKIE_RESET = 32'h2112_A442;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int FILL_LIMIT = FIFO_DEPTH - 2;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_ATTR_HDR = 3'd1,
        PH_VALUE    = 3'd2,
        PH_PAD      = 3'd3,
        PH_IDLE     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER     = 2'd0,
        KIND_ATTR_START = 2'd1,
        KIND_VALUE      = 2'd2,
        KIND_END        = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_LEN_EXCEEDS = 3'd2,
        ST_BAD_COOKIE  = 3'd3,
        ST_TRUNCATED   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] msg_type;
        logic [15:0] msg_length;
        logic [31:0] txn_id_high;
        logic [63:0] txn_id_low;
        logic [15:0] attribute_type;
        logic [15:0] attribute_length;
        logic [7:0]  value_byte;
        logic [15:0] value_index;
        status_t     status;
        logic        end_of_message;
    } rsp_t;

    // One or two results written into the result queue in a cycle.
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// File: rtl/stun_message_parser.sv
// Top level of the STUN message parser: byte request channel, result channel, cookie register.
// Depends on smp_pkg, smp_parse_core and smp_result_fifo.
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+------------------------------
//   req       | in        | req_valid / req_stall | smp_pkg::req_t (byte, last)
//   rsp       | out       | rsp_valid / rsp_stall | smp_pkg::rsp_t (one result)
//   cookie    | in        | cookie_write_en       | 32-bit expected magic cookie
//
// Each accepted byte updates the parse state in the same cycle and writes its
// results (none, one, or two when a header, attribute or value result coincides
// with the final byte) into a four-entry result queue; the registered head of
// the queue drives rsp. One byte is taken per clock while at most two
// results wait; a byte that yields two results stalls the input only when it
// leaves more than two results waiting.
// rsp_stall holds the queue head; req_stall rises when more than two results wait.
// Reset (rst_n low, asynchronous) clears the parse state and queue and loads the
// standard cookie 0x2112A442 into the cookie register.
module stun_message_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  smp_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output smp_pkg::rsp_t rsp_data,
    input  logic          cookie_write_en,
    input  logic [31:0]   cookie_write_data
);

    logic           room;
    logic           accept;
    smp_pkg::push_t push;
    smp_pkg::rsp_t  rsp_first;
    smp_pkg::rsp_t  rsp_second;

    // Take a request whenever the queue can absorb the worst case of two results.
    assign req_stall = !room;
    assign accept    = req_valid && room;

    smp_parse_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .req               (req_data),
        .cookie_write_en   (cookie_write_en),
        .cookie_write_data (cookie_write_data),
        .push              (push),
        .rsp_first         (rsp_first),
        .rsp_second        (rsp_second)
    );

    smp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_first  (rsp_first),
        .wr_second (rsp_second),
        .room      (room),
        .rd_valid  (rsp_valid),
        .rd_stall  (rsp_stall),
        .rd_data   (rsp_data)
    );

endmodule

// File: rtl/smp_parse_core.sv
// Byte-wise STUN parse state and result generation, one byte per accepted request.
// Depends on smp_pkg.
module smp_parse_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  smp_pkg::req_t       req,
    input  logic                cookie_write_en,
    input  logic [31:0]         cookie_write_data,
    output smp_pkg::push_t      push,
    output smp_pkg::rsp_t       rsp_first,
    output smp_pkg::rsp_t       rsp_second
);

    logic [smp_pkg::POS_W-1:0] pos_reg, pos_next;
    smp_pkg::phase_t           phase_reg, phase_next;
    logic [15:0]               htype_reg, htype_next;
    logic [15:0]               hlen_reg, hlen_next;
    logic [31:0]               cookie_reg, cookie_next;
    logic [31:0]               txnu_reg, txnu_next;
    logic [63:0]               txnl_reg, txnl_next;
    logic [31:0]               ahs_reg, ahs_next;
    logic [smp_pkg::LEN_W-1:0] abl_reg, abl_next;
    logic [smp_pkg::LEN_W-1:0] area_reg, area_next;
    logic                      bad_reg, bad_next;
    logic [31:0]               expected_cookie_reg;

    logic                      prim_valid;
    smp_pkg::rsp_t             prim;
    smp_pkg::rsp_t             fin;
    logic [7:0]                b;
    logic [15:0]               alen;
    logic [1:0]                pad;
    logic [smp_pkg::POS_W-1:0] len_plus;

    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        htype_next  = htype_reg;
        hlen_next   = hlen_reg;
        cookie_next = cookie_reg;
        txnu_next   = txnu_reg;
        txnl_next   = txnl_reg;
        ahs_next    = ahs_reg;
        abl_next    = abl_reg;
        area_next   = area_reg;
        bad_next    = bad_reg;
        prim_valid  = 1'b0;
        prim        = '0;
        fin         = '0;
        b           = req.data_byte;
        alen        = ahs_reg[15:0];
        pad         = 2'd0;
        len_plus    = '0;

        // consume one byte of the declared attribute area
        if ((phase_reg == smp_pkg::PH_ATTR_HDR || phase_reg == smp_pkg::PH_VALUE ||
             phase_reg == smp_pkg::PH_PAD) && area_reg != '0)
        begin
            area_next = area_reg - 1'b1;
        end

        unique case (phase_reg)
            smp_pkg::PH_HEADER:
            begin
                if (pos_reg < smp_pkg::POS_W'(2))
                begin
                    htype_next = {htype_reg[7:0], b};
                end
                else if (pos_reg < smp_pkg::POS_W'(4))
                begin
                    hlen_next = {hlen_reg[7:0], b};
                    area_next = hlen_next;
                end
                else if (pos_reg < smp_pkg::POS_W'(8))
                begin
                    cookie_next = {cookie_reg[23:0], b};
                end
                else if (pos_reg < smp_pkg::POS_W'(smp_pkg::TXN_HIGH_END))
                begin
                    txnu_next = {txnu_reg[23:0], b};
                end
                else if (pos_reg < smp_pkg::POS_W'(smp_pkg::HEADER_BYTES))
                begin
                    txnl_next = {txnl_reg[55:0], b};
                end

                if (pos_reg == smp_pkg::POS_W'(smp_pkg::HEADER_BYTES - 1))
                begin
                    prim_valid       = 1'b1;
                    prim.kind        = smp_pkg::KIND_HEADER;
                    prim.msg_type    = htype_next;
                    prim.msg_length  = hlen_next;
                    prim.txn_id_high = txnu_next;
                    prim.txn_id_low  = txnl_next;
                    if (cookie_next != expected_cookie_reg)
                    begin
                        bad_next   = 1'b1;
                        phase_next = smp_pkg::PH_IDLE;
                    end
                    else if (hlen_next == '0)
                    begin
                        phase_next = smp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = smp_pkg::PH_ATTR_HDR;
                        abl_next   = smp_pkg::LEN_W'(smp_pkg::ATTR_HEADER_BYTES);
                    end
                end
                else if (pos_reg >= smp_pkg::POS_W'(smp_pkg::HEADER_BYTES))
                begin
                    phase_next = smp_pkg::PH_IDLE;
                end
            end

            smp_pkg::PH_ATTR_HDR:
            begin
                ahs_next = {ahs_reg[23:0], b};
                if (abl_reg != '0)
                begin
                    abl_next = abl_reg - 1'b1;
                end
                if (abl_next == '0)
                begin
                    prim_valid            = 1'b1;
                    prim.kind             = smp_pkg::KIND_ATTR_START;
                    prim.attribute_type   = ahs_next[31:16];
                    prim.attribute_length = ahs_next[15:0];
                    if (ahs_next[15:0] != '0)
                    begin
                        phase_next = smp_pkg::PH_VALUE;
                        abl_next   = ahs_next[15:0];
                    end
                    else if (area_next == '0)
                    begin
                        phase_next = smp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = smp_pkg::PH_ATTR_HDR;
                        abl_next   = smp_pkg::LEN_W'(smp_pkg::ATTR_HEADER_BYTES);
                    end
                end
            end

            smp_pkg::PH_VALUE:
            begin
                prim_valid            = 1'b1;
                prim.kind             = smp_pkg::KIND_VALUE;
                prim.attribute_type   = ahs_reg[31:16];
                prim.attribute_length = alen;
                prim.value_byte       = b;
                prim.value_index      = alen - abl_reg;
                if (abl_reg != '0)
                begin
                    abl_next = abl_reg - 1'b1;
                end
                if (abl_next == '0)
                begin
                    // padding up to the next multiple of four
                    pad = 2'(2'd0 - alen[1:0]) & 2'(smp_pkg::PAD_MASK);
                    if (pad != 2'd0)
                    begin
                        phase_next = smp_pkg::PH_PAD;
                        abl_next   = smp_pkg::LEN_W'(pad);
                    end
                    else if (area_next == '0)
                    begin
                        phase_next = smp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = smp_pkg::PH_ATTR_HDR;
                        abl_next   = smp_pkg::LEN_W'(smp_pkg::ATTR_HEADER_BYTES);
                    end
                end
            end

            smp_pkg::PH_PAD:
            begin
                if (abl_reg != '0)
                begin
                    abl_next = abl_reg - 1'b1;
                end
                if (abl_next == '0)
                begin
                    if (area_next == '0)
                    begin
                        phase_next = smp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = smp_pkg::PH_ATTR_HDR;
                        abl_next   = smp_pkg::LEN_W'(smp_pkg::ATTR_HEADER_BYTES);
                    end
                end
            end

            default:
            begin
                phase_next = smp_pkg::PH_IDLE;
            end
        endcase

        if (pos_reg != smp_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end

        if (req.last)
        begin
            // total = pos + 1; length exceeds data when hlen > total - 20
            len_plus           = smp_pkg::POS_W'(hlen_next) +
                                 smp_pkg::POS_W'(smp_pkg::HEADER_BYTES - 1);
            fin.kind           = smp_pkg::KIND_END;
            fin.end_of_message = 1'b1;
            if (pos_reg < smp_pkg::POS_W'(smp_pkg::HEADER_BYTES - 1))
            begin
                fin.status = smp_pkg::ST_TOO_SHORT;
            end
            else if (len_plus > pos_reg)
            begin
                fin.status = smp_pkg::ST_LEN_EXCEEDS;
            end
            else if (bad_next)
            begin
                fin.status = smp_pkg::ST_BAD_COOKIE;
            end
            else if (phase_next == smp_pkg::PH_ATTR_HDR || phase_next == smp_pkg::PH_VALUE ||
                     phase_next == smp_pkg::PH_PAD)
            begin
                fin.status = smp_pkg::ST_TRUNCATED;
            end
            else
            begin
                fin.status = smp_pkg::ST_OK;
            end

            // drop all parse state for the next message
            pos_next    = '0;
            phase_next  = smp_pkg::PH_HEADER;
            htype_next  = '0;
            hlen_next   = '0;
            cookie_next = '0;
            txnu_next   = '0;
            txnl_next   = '0;
            ahs_next    = '0;
            abl_next    = '0;
            area_next   = '0;
            bad_next    = 1'b0;
        end
    end

    always_comb
    begin
        push.first  = accept && (prim_valid || req.last);
        push.second = accept && prim_valid && req.last;
        rsp_first   = prim_valid ? prim : fin;
        rsp_second  = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= smp_pkg::PH_HEADER;
            htype_reg  <= '0;
            hlen_reg   <= '0;
            cookie_reg <= '0;
            txnu_reg   <= '0;
            txnl_reg   <= '0;
            ahs_reg    <= '0;
            abl_reg    <= '0;
            area_reg   <= '0;
            bad_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            htype_reg  <= htype_next;
            hlen_reg   <= hlen_next;
            cookie_reg <= cookie_next;
            txnu_reg   <= txnu_next;
            txnl_reg   <= txnl_next;
            ahs_reg    <= ahs_next;
            abl_reg    <= abl_next;
            area_reg   <= area_next;
            bad_reg    <= bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_cookie_reg <= smp_pkg::COOKIE_RESET;
        end
        else if (cookie_write_en)
        begin
            expected_cookie_reg <= cookie_write_data;
        end
    end

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.last) |=> (pos_reg == '0 && phase_reg == smp_pkg::PH_HEADER))
        else $error("parse state not cleared after final byte");

    a_bad_cookie_idle: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg |-> (phase_reg == smp_pkg::PH_IDLE))
        else $error("attribute walk after cookie mismatch");

    a_second_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> (rsp_second.kind == smp_pkg::KIND_END && push.first))
        else $error("second result is not an end status");

endmodule

// File: rtl/smp_result_fifo.sv
// Four-entry result queue taking up to two results a cycle and giving one while rd_stall is low.
// Depends on smp_pkg.
module smp_result_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  smp_pkg::push_t push,
    input  smp_pkg::rsp_t  wr_first,
    input  smp_pkg::rsp_t  wr_second,
    output logic           room,
    output logic           rd_valid,
    input  logic           rd_stall,
    output smp_pkg::rsp_t  rd_data
);

    smp_pkg::rsp_t               slot_reg [smp_pkg::FIFO_DEPTH];
    logic [smp_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [smp_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [smp_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [smp_pkg::PTR_W-1:0]   wr_ptr_plus;
    logic                        pop;

    always_comb
    begin
        wr_ptr_plus = wr_ptr_reg + 1'b1;
        pop         = rd_valid && !rd_stall;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + smp_pkg::PTR_W'(push.first) + smp_pkg::PTR_W'(push.second);
        count_next  = count_reg + smp_pkg::CNT_W'(push.first) + smp_pkg::CNT_W'(push.second)
                      - smp_pkg::CNT_W'(pop);
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign room     = (count_reg <= smp_pkg::CNT_W'(smp_pkg::FILL_LIMIT));

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            slot_reg[wr_ptr_reg] <= wr_first;
        end
        if (push.second)
        begin
            slot_reg[wr_ptr_plus] <= wr_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> (count_reg <= smp_pkg::CNT_W'(smp_pkg::FILL_LIMIT)))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= smp_pkg::CNT_W'(smp_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (smp_pkg::PTR_W'(wr_ptr_reg - rd_ptr_reg) == smp_pkg::PTR_W'(count_reg)))
        else $error("result queue pointers disagree with count");

endmodule
